@@ hw/rtl/grid_ray_traversal_dda_top_defines.svh @@
`ifndef GRID_RAY_TRAVERSAL_DDA_TOP_DEFINES_SVH
`define GRID_RAY_TRAVERSAL_DDA_TOP_DEFINES_SVH

// same-cycle implication
`define GDDA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define GDDA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/gdda_pkg.sv @@
package gdda_pkg;

  localparam int unsigned LEN_W      = 40;
  localparam int unsigned COORD_W    = 10;
  localparam int unsigned TILE_W     = 41;
  localparam int unsigned DIST_W     = 22;
  localparam logic [21:0] DIST_MAX   = 22'h3FFFFF;
  localparam logic [21:0] MAXD_RESET = 22'd1310720;

  typedef enum logic [1:0] {
    ST_TRANSP = 2'd0,
    ST_SOLID  = 2'd1,
    ST_NOHIT  = 2'd2
  } status_e;

  typedef enum logic [0:0] {
    OP_SQRT = 1'b0,
    OP_DIV  = 1'b1
  } alu_op_e;

  typedef struct packed {
    logic    start;
    alu_op_e op;
  } alu_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] result;
  } alu_rsp_t;

endpackage

@@ hw/rtl/gdda_ram.sv @@
module gdda_ram #(
  parameter int unsigned WIDTH = 41,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/gdda_alu.sv @@
module gdda_alu (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  gdda_pkg::alu_req_t req_i,
  input  logic [63:0]       operand_i,
  input  logic [15:0]       divisor_i,
  output gdda_pkg::alu_rsp_t rsp_o
);

  logic             run_q, run_d;
  logic             done_q, done_d;
  logic [4:0]       cnt_q, cnt_d;
  gdda_pkg::alu_op_e op_q, op_d;
  logic [63:0]      acc_q, acc_d;
  logic [35:0]      rem_q, rem_d;
  logic [31:0]      root_q, root_d;
  logic [15:0]      dvs_q, dvs_d;
  logic [35:0]      rem_sh, trial;
  logic             fits;

  always_comb begin
    if (op_q == gdda_pkg::OP_SQRT) begin
      rem_sh = {rem_q[33:0], acc_q[63:62]};
      trial  = {2'b00, root_q, 2'b01};
    end else begin
      rem_sh = {rem_q[34:0], acc_q[63]};
      trial  = {20'd0, dvs_q};
    end
    fits = rem_sh >= trial;
  end

  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    op_d   = op_q;
    acc_d  = acc_q;
    rem_d  = rem_q;
    root_d = root_q;
    dvs_d  = dvs_q;
    if (req_i.start) begin
      run_d  = 1'b1;
      cnt_d  = 5'd0;
      op_d   = req_i.op;
      acc_d  = operand_i;
      rem_d  = 36'd0;
      root_d = 32'd0;
      dvs_d  = divisor_i;
    end else if (run_q) begin
      rem_d  = fits ? rem_sh - trial : rem_sh;
      root_d = {root_q[30:0], fits};
      acc_d  = (op_q == gdda_pkg::OP_SQRT) ? {acc_q[61:0], 2'b00} : {acc_q[62:0], 1'b0};
      cnt_d  = cnt_q + 5'd1;
      if (cnt_q == 5'd31) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 5'd0;
      op_q   <= gdda_pkg::OP_SQRT;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
      op_q   <= op_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    rem_q  <= rem_d;
    root_q <= root_d;
    dvs_q  <= dvs_d;
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.result = root_q;

endmodule

@@ hw/rtl/grid_ray_traversal_dda_top.sv @@
// Tile-map ray caster. After reset the map is cleared one cell per cycle,
// over all MAP_SIDE*MAP_SIDE cells (4096 by default), and no item is taken
// meanwhile; the max_distance register can be written at any time. A cast
// squares the direction components, takes the length square root and then
// divides by each nonzero direction component, all on one shared
// bit-serial square-root/divide unit, and sets up the first lengths; then
// each cell stepped takes a check, a step, a map read from the map memory's
// registered read port and an evaluation, plus an emit step per reported
// result; a result waits while the previous one is still held in the output
// register. A cast with a zero direction goes straight to its single result.
// One item is in work at a time; the result register lets the next item in
// while the last result still waits.
`include "grid_ray_traversal_dda_top_defines.svh"

module grid_ray_traversal_dda_top #(
  parameter int unsigned MAP_SIDE  = 64,
  parameter int unsigned MAX_TILES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [21:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        kind_i,
  input  logic [5:0]  cell_x_i,
  input  logic [5:0]  cell_y_i,
  input  logic [7:0]  tile_code_i,
  input  logic [23:0] tile_color_i,
  input  logic [7:0]  tile_height_i,
  input  logic        tile_see_through_i,
  input  logic [21:0] origin_x_i,
  input  logic [21:0] origin_y_i,
  input  logic signed [15:0] dir_x_i,
  input  logic signed [15:0] dir_y_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [7:0]  hit_code_o,
  output logic [23:0] hit_color_o,
  output logic [7:0]  hit_height_o,
  output logic        hit_see_through_o,
  output logic [21:0] ray_distance_o,
  output logic        hit_side_o,
  output logic [5:0]  hit_x_o,
  output logic [5:0]  hit_y_o,
  output logic        last_o
);

  localparam int unsigned DEPTH = MAP_SIDE * MAP_SIDE;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned NW    = $clog2(MAX_TILES);
  localparam int unsigned LW    = gdda_pkg::LEN_W;
  localparam int unsigned CW    = gdda_pkg::COORD_W;

  typedef enum logic [13:0] {
    S_CLEAR = 14'b00000000000001,
    S_IDLE  = 14'b00000000000010,
    S_SQ_X  = 14'b00000000000100,
    S_SQ_Y  = 14'b00000000001000,
    S_SQRT  = 14'b00000000010000,
    S_DIVX  = 14'b00000000100000,
    S_DIVY  = 14'b00000001000000,
    S_LEN_X = 14'b00000010000000,
    S_LEN_Y = 14'b00000100000000,
    S_CHECK = 14'b00001000000000,
    S_STEP  = 14'b00010000000000,
    S_READ  = 14'b00100000000000,
    S_EVAL  = 14'b01000000000000,
    S_EMIT  = 14'b10000000000000
  } state_e;

  state_e state_q, state_d;

  logic [AW-1:0] clr_q, clr_d;
  logic          go_q, go_d;
  logic [21:0]   maxd_q, maxd_d;

  logic          negx_q, negx_d, negy_q, negy_d;
  logic          xv_q, xv_d, yv_q, yv_d;
  logic [15:0]   adx_q, adx_d, ady_q, ady_d;
  logic [15:0]   fx_q, fx_d, fy_q, fy_d;
  logic [CW-1:0] cx_q, cx_d, cy_q, cy_d;
  logic [31:0]   sumsq_q, sumsq_d;
  logic [31:0]   mag_q, mag_d;
  logic [31:0]   ux_q, ux_d, uy_q, uy_d;
  logic [LW-1:0] rx_q, rx_d, ry_q, ry_d, dist_q, dist_d;
  logic [NW-1:0] ntr_q, ntr_d;

  logic [1:0]    pst_q, pst_d;
  logic [gdda_pkg::TILE_W-1:0] ptile_q, ptile_d;
  logic          pside_q, pside_d;
  logic [5:0]    px_q, px_d, py_q, py_d;
  logic          plast_q, plast_d;

  logic          ov_q, ov_d;
  logic [1:0]    ost_q, ost_d;
  logic [gdda_pkg::TILE_W-1:0] otile_q, otile_d;
  logic [21:0]   odist_q, odist_d;
  logic          oside_q, oside_d;
  logic [5:0]    ox_q, ox_d, oy_q, oy_d;
  logic          olast_q, olast_d;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [gdda_pkg::TILE_W-1:0] wdata, rdata;

  gdda_pkg::alu_req_t alu_req;
  gdda_pkg::alu_rsp_t alu_rsp;
  logic [63:0]   alu_opnd;
  logic [15:0]   alu_dvs;

  logic [16:0]   mul_a;
  logic [31:0]   mul_b;
  logic [48:0]   prod;

  logic          take_x;
  logic [CW-1:0] ncx, ncy;
  logic          leave;
  logic          in_xfer, cfg_xfer, cast_zero;

  gdda_ram #(
    .WIDTH (gdda_pkg::TILE_W),
    .DEPTH (DEPTH)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  gdda_alu u_alu (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (alu_req),
    .operand_i (alu_opnd),
    .divisor_i (alu_dvs),
    .rsp_o     (alu_rsp)
  );

  assign cfg_ready_o = 1'b1;
  assign cfg_xfer    = cfg_valid_i & cfg_ready_o;
  assign in_ready_o  = (state_q == S_IDLE);
  assign in_xfer     = in_valid_i & in_ready_o;
  assign cast_zero   = (dir_x_i == 16'sd0) && (dir_y_i == 16'sd0);

  // map port: clearing pass or cell write
  always_comb begin
    we    = 1'b0;
    waddr = clr_q;
    wdata = '0;
    if (state_q == S_CLEAR) begin
      we = 1'b1;
    end else if (in_xfer && !kind_i && (32'(cell_x_i) < MAP_SIDE)
                 && (32'(cell_y_i) < MAP_SIDE)) begin
      we    = 1'b1;
      waddr = AW'(cell_y_i) * AW'(MAP_SIDE) + AW'(cell_x_i);
      wdata = {tile_see_through_i, tile_height_i, tile_color_i, tile_code_i};
    end
  end

  assign raddr = AW'(cy_q) * AW'(MAP_SIDE) + AW'(cx_q);

  // shared multiplier
  always_comb begin
    unique case (state_q)
      S_SQ_X: begin
        mul_a = {1'b0, adx_q};
        mul_b = {16'd0, adx_q};
      end
      S_SQ_Y: begin
        mul_a = {1'b0, ady_q};
        mul_b = {16'd0, ady_q};
      end
      S_LEN_X: begin
        mul_a = negx_q ? {1'b0, fx_q} : 17'h10000 - {1'b0, fx_q};
        mul_b = ux_q;
      end
      default: begin
        mul_a = negy_q ? {1'b0, fy_q} : 17'h10000 - {1'b0, fy_q};
        mul_b = uy_q;
      end
    endcase
    prod = 49'(mul_a) * 49'(mul_b);
  end

  always_comb begin
    alu_req.start = go_q & ((state_q == S_SQRT) | (state_q == S_DIVX) | (state_q == S_DIVY));
    alu_req.op    = (state_q == S_SQRT) ? gdda_pkg::OP_SQRT : gdda_pkg::OP_DIV;
    alu_opnd      = (state_q == S_SQRT) ? {sumsq_q, 32'd0} : {mag_q, 32'd0};
    alu_dvs       = (state_q == S_DIVX) ? adx_q : ady_q;
  end

  // one cell step
  always_comb begin
    take_x = xv_q && (!yv_q || (rx_q < ry_q));
    ncx    = cx_q + (negx_q ? {CW{1'b1}} : CW'(1));
    ncy    = cy_q + (negy_q ? {CW{1'b1}} : CW'(1));
    if (take_x) begin
      leave = ncx[CW-1] || (32'(ncx) >= MAP_SIDE);
    end else begin
      leave = ncy[CW-1] || (32'(ncy) >= MAP_SIDE);
    end
  end

  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    go_d    = 1'b0;
    maxd_d  = cfg_xfer ? cfg_data_i : maxd_q;
    negx_d  = negx_q;
    negy_d  = negy_q;
    xv_d    = xv_q;
    yv_d    = yv_q;
    adx_d   = adx_q;
    ady_d   = ady_q;
    fx_d    = fx_q;
    fy_d    = fy_q;
    cx_d    = cx_q;
    cy_d    = cy_q;
    sumsq_d = sumsq_q;
    mag_d   = mag_q;
    ux_d    = ux_q;
    uy_d    = uy_q;
    rx_d    = rx_q;
    ry_d    = ry_q;
    dist_d  = dist_q;
    ntr_d   = ntr_q;
    pst_d   = pst_q;
    ptile_d = ptile_q;
    pside_d = pside_q;
    px_d    = px_q;
    py_d    = py_q;
    plast_d = plast_q;
    ov_d    = ov_q & ~out_ready_i;
    ost_d   = ost_q;
    otile_d = otile_q;
    odist_d = odist_q;
    oside_d = oside_q;
    ox_d    = ox_q;
    oy_d    = oy_q;
    olast_d = olast_q;

    unique case (state_q)
      S_CLEAR: begin
        clr_d = clr_q + AW'(1);
        if (clr_q == AW'(DEPTH - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_xfer && kind_i) begin
          negx_d = dir_x_i[15];
          negy_d = dir_y_i[15];
          xv_d   = dir_x_i != 16'sd0;
          yv_d   = dir_y_i != 16'sd0;
          adx_d  = dir_x_i[15] ? 16'(-dir_x_i) : dir_x_i;
          ady_d  = dir_y_i[15] ? 16'(-dir_y_i) : dir_y_i;
          fx_d   = origin_x_i[15:0];
          fy_d   = origin_y_i[15:0];
          cx_d   = CW'(origin_x_i[21:16]);
          cy_d   = CW'(origin_y_i[21:16]);
          ux_d   = 32'd0;
          uy_d   = 32'd0;
          dist_d = '0;
          ntr_d  = '0;
          if (cast_zero) begin
            pst_d   = gdda_pkg::ST_NOHIT;
            ptile_d = '0;
            pside_d = 1'b0;
            px_d    = 6'd0;
            py_d    = 6'd0;
            plast_d = 1'b1;
            state_d = S_EMIT;
          end else begin
            state_d = S_SQ_X;
          end
        end
      end
      S_SQ_X: begin
        sumsq_d = prod[31:0];
        state_d = S_SQ_Y;
      end
      S_SQ_Y: begin
        sumsq_d = sumsq_q + prod[31:0];
        go_d    = 1'b1;
        state_d = S_SQRT;
      end
      S_SQRT: begin
        if (alu_rsp.done) begin
          mag_d   = alu_rsp.result;
          go_d    = 1'b1;
          state_d = xv_q ? S_DIVX : S_DIVY;
        end
      end
      S_DIVX: begin
        if (alu_rsp.done) begin
          ux_d    = alu_rsp.result;
          go_d    = yv_q;
          state_d = yv_q ? S_DIVY : S_LEN_X;
        end
      end
      S_DIVY: begin
        if (alu_rsp.done) begin
          uy_d    = alu_rsp.result;
          state_d = S_LEN_X;
        end
      end
      S_LEN_X: begin
        rx_d    = LW'(prod[48:16]);
        state_d = S_LEN_Y;
      end
      S_LEN_Y: begin
        ry_d    = LW'(prod[48:16]);
        state_d = S_CHECK;
      end
      S_CHECK: begin
        if (dist_q < LW'(maxd_q)) begin
          state_d = S_STEP;
        end else begin
          pst_d   = gdda_pkg::ST_NOHIT;
          ptile_d = '0;
          pside_d = 1'b0;
          px_d    = 6'd0;
          py_d    = 6'd0;
          plast_d = 1'b1;
          state_d = S_EMIT;
        end
      end
      S_STEP: begin
        if (take_x) begin
          cx_d    = ncx;
          dist_d  = rx_q;
          rx_d    = rx_q + LW'(ux_q);
          pside_d = 1'b0;
        end else begin
          cy_d    = ncy;
          dist_d  = ry_q;
          ry_d    = ry_q + LW'(uy_q);
          pside_d = 1'b1;
        end
        if (leave) begin
          pst_d   = gdda_pkg::ST_NOHIT;
          ptile_d = '0;
          pside_d = 1'b0;
          px_d    = 6'd0;
          py_d    = 6'd0;
          plast_d = 1'b1;
          state_d = S_EMIT;
        end else begin
          state_d = S_READ;
        end
      end
      S_READ: begin
        state_d = S_EVAL;
      end
      S_EVAL: begin
        ptile_d = rdata;
        px_d    = cx_q[5:0];
        py_d    = cy_q[5:0];
        state_d = S_CHECK;
        if (rdata[7:0] != 8'd0) begin
          if (!rdata[40]) begin
            pst_d   = gdda_pkg::ST_SOLID;
            plast_d = 1'b1;
            state_d = S_EMIT;
          end else if (32'(ntr_q) < MAX_TILES - 1) begin
            pst_d   = gdda_pkg::ST_TRANSP;
            plast_d = 1'b0;
            ntr_d   = ntr_q + NW'(1);
            state_d = S_EMIT;
          end
        end
      end
      S_EMIT: begin
        if (!ov_q || out_ready_i) begin
          ov_d    = 1'b1;
          ost_d   = pst_q;
          otile_d = ptile_q;
          odist_d = (dist_q > LW'(gdda_pkg::DIST_MAX)) ? gdda_pkg::DIST_MAX : dist_q[21:0];
          oside_d = pside_q;
          ox_d    = px_q;
          oy_d    = py_q;
          olast_d = plast_q;
          state_d = plast_q ? S_IDLE : S_CHECK;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      go_q    <= 1'b0;
      maxd_q  <= gdda_pkg::MAXD_RESET;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      go_q    <= go_d;
      maxd_q  <= maxd_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    negx_q  <= negx_d;
    negy_q  <= negy_d;
    xv_q    <= xv_d;
    yv_q    <= yv_d;
    adx_q   <= adx_d;
    ady_q   <= ady_d;
    fx_q    <= fx_d;
    fy_q    <= fy_d;
    cx_q    <= cx_d;
    cy_q    <= cy_d;
    sumsq_q <= sumsq_d;
    mag_q   <= mag_d;
    ux_q    <= ux_d;
    uy_q    <= uy_d;
    rx_q    <= rx_d;
    ry_q    <= ry_d;
    dist_q  <= dist_d;
    ntr_q   <= ntr_d;
    pst_q   <= pst_d;
    ptile_q <= ptile_d;
    pside_q <= pside_d;
    px_q    <= px_d;
    py_q    <= py_d;
    plast_q <= plast_d;
    ost_q   <= ost_d;
    otile_q <= otile_d;
    odist_q <= odist_d;
    oside_q <= oside_d;
    ox_q    <= ox_d;
    oy_q    <= oy_d;
    olast_q <= olast_d;
  end

  assign out_valid_o       = ov_q;
  assign status_o          = ost_q;
  assign hit_code_o        = otile_q[7:0];
  assign hit_color_o       = otile_q[31:8];
  assign hit_height_o      = otile_q[39:32];
  assign hit_see_through_o = otile_q[40];
  assign ray_distance_o    = odist_q;
  assign hit_side_o        = oside_q;
  assign hit_x_o           = ox_q;
  assign hit_y_o           = oy_q;
  assign last_o            = olast_q;

  `GDDA_ASSERT_NOW(a_last_status, out_valid_o, last_o == (status_o != gdda_pkg::ST_TRANSP), "last flag disagrees with status")
  `GDDA_ASSERT_NOW(a_nohit_clean, out_valid_o && (status_o == gdda_pkg::ST_NOHIT), (hit_code_o == 8'd0) && (hit_x_o == 6'd0) && (hit_y_o == 6'd0) && !hit_side_o, "no-hit result carries tile data")
  `GDDA_ASSERT_NOW(a_alu_done_owned, alu_rsp.done, (state_q == S_SQRT) || (state_q == S_DIVX) || (state_q == S_DIVY), "alu finished outside a setup state")
  `GDDA_ASSERT_NEXT(a_cast_busy, in_valid_i && in_ready_o && kind_i, !in_ready_o, "ready right after a cast transfer")

endmodule

@@ verif/testbench.sv @@
module testbench;

  localparam int unsigned MAP_SIDE = 64;
  localparam int unsigned MAX_TILES = 16;
  localparam int unsigned CYCLE_LIMIT = 3000000;
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_CAST = 1'b1;

  typedef struct packed {
    gdda_pkg::status_e status;
    logic [7:0]  code;
    logic [23:0] color;
    logic [7:0]  height;
    logic        see;
    logic [21:0] rdist;
    logic        side;
    logic [5:0]  x;
    logic [5:0]  y;
    logic        last;
  } hit_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [21:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic kind_i = 1'b0;
  logic [5:0] cell_x_i = '0;
  logic [5:0] cell_y_i = '0;
  logic [7:0] tile_code_i = '0;
  logic [23:0] tile_color_i = '0;
  logic [7:0] tile_height_i = '0;
  logic tile_see_through_i = 1'b0;
  logic [21:0] origin_x_i = '0;
  logic [21:0] origin_y_i = '0;
  logic signed [15:0] dir_x_i = '0;
  logic signed [15:0] dir_y_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [1:0] status_o;
  logic [7:0] hit_code_o;
  logic [23:0] hit_color_o;
  logic [7:0] hit_height_o;
  logic hit_see_through_o;
  logic [21:0] ray_distance_o;
  logic hit_side_o;
  logic [5:0] hit_x_o;
  logic [5:0] hit_y_o;
  logic last_o;

  grid_ray_traversal_dda_top uut (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_data_i,
    .in_valid_i, .in_ready_o, .kind_i, .cell_x_i, .cell_y_i, .tile_code_i,
    .tile_color_i, .tile_height_i, .tile_see_through_i, .origin_x_i,
    .origin_y_i, .dir_x_i, .dir_y_i, .out_valid_o, .out_ready_i, .status_o,
    .hit_code_o, .hit_color_o, .hit_height_o, .hit_see_through_o,
    .ray_distance_o, .hit_side_o, .hit_x_o, .hit_y_o, .last_o
  );

  // model state
  logic [7:0] map_code[MAP_SIDE*MAP_SIDE];
  logic [23:0] map_color[MAP_SIDE*MAP_SIDE];
  logic [7:0] map_height[MAP_SIDE*MAP_SIDE];
  logic map_see[MAP_SIDE*MAP_SIDE];
  logic [21:0] max_dist_q;
  hit_t hits_pending[$];

  int unsigned sender_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned mismatches = 0;
  int unsigned n_casts = 0;
  int unsigned n_writes = 0;
  int unsigned n_results = 0;
  int unsigned n_transp = 0;
  int unsigned cycles = 0;

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(negedge clk_i) out_ready_i <= ($urandom_range(99) >= recv_stall_pct);

  function automatic longint unsigned isqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic void push_hit(gdda_pkg::status_e st, int idx, bit has_tile,
                                   longint unsigned d, bit sd, int x, int y);
    hit_t h;
    h.status = st;
    h.code = has_tile ? map_code[idx] : '0;
    h.color = has_tile ? map_color[idx] : '0;
    h.height = has_tile ? map_height[idx] : '0;
    h.see = has_tile ? map_see[idx] : 1'b0;
    h.rdist = (d > 64'd4194303) ? gdda_pkg::DIST_MAX : d[21:0];
    h.side = sd;
    h.x = x[5:0];
    h.y = y[5:0];
    h.last = (st != gdda_pkg::ST_TRANSP);
    hits_pending.push_back(h);
  endfunction

  function automatic void trace_ray(logic [21:0] ox, logic [21:0] oy,
                                    logic signed [15:0] dx, logic signed [15:0] dy);
    longint unsigned adx, ady, mag, ux, uy, rx, ry, fx, fy, d;
    int cx, cy, sx, sy, n, idx;
    bit xv, yv, sd;
    adx = (dx < 0) ? -longint'(dx) : longint'(dx);
    ady = (dy < 0) ? -longint'(dy) : longint'(dy);
    xv = adx != 0;
    yv = ady != 0;
    d = 0;
    n = 0;
    if (!xv && !yv) begin
      push_hit(gdda_pkg::ST_NOHIT, 0, 1'b0, 0, 1'b0, 0, 0);
      return;
    end
    mag = isqrt((adx * adx + ady * ady) << 32);
    ux = xv ? mag / adx : 0;
    uy = yv ? mag / ady : 0;
    cx = ox >> 16;
    cy = oy >> 16;
    fx = ox[15:0];
    fy = oy[15:0];
    sx = (dx < 0) ? -1 : 1;
    sy = (dy < 0) ? -1 : 1;
    rx = (((dx < 0) ? fx : 65536 - fx) * ux) >> 16;
    ry = (((dy < 0) ? fy : 65536 - fy) * uy) >> 16;
    while (d < max_dist_q) begin
      if (xv && (!yv || rx < ry)) begin
        cx += sx;
        d = rx;
        rx += ux;
        sd = 1'b0;
      end else begin
        cy += sy;
        d = ry;
        ry += uy;
        sd = 1'b1;
      end
      if (cx < 0 || cy < 0 || cx >= MAP_SIDE || cy >= MAP_SIDE) break;
      idx = cy * MAP_SIDE + cx;
      if (map_code[idx] == 0) continue;
      if (map_see[idx]) begin
        if (n < MAX_TILES - 1) begin
          push_hit(gdda_pkg::ST_TRANSP, idx, 1'b1, d, sd, cx, cy);
          n++;
        end
      end else begin
        push_hit(gdda_pkg::ST_SOLID, idx, 1'b1, d, sd, cx, cy);
        return;
      end
    end
    push_hit(gdda_pkg::ST_NOHIT, 0, 1'b0, d, 1'b0, 0, 0);
  endfunction

  // result checker
  always @(posedge clk_i) begin
    hit_t got, want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = {gdda_pkg::status_e'(status_o), hit_code_o, hit_color_o, hit_height_o,
             hit_see_through_o, ray_distance_o, hit_side_o, hit_x_o, hit_y_o, last_o};
      n_results++;
      if (status_o == gdda_pkg::ST_TRANSP) n_transp++;
      if (hits_pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
      end else begin
        want = hits_pending.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: exp st=%0d code=%h col=%h h=%h see=%b d=%h side=%b x=%0d y=%0d last=%b",
                     want.status, want.code, want.color, want.height, want.see,
                     want.rdist, want.side, want.x, want.y, want.last);
            $display("          act st=%0d code=%h col=%h h=%h see=%b d=%h side=%b x=%0d y=%0d last=%b",
                     got.status, got.code, got.color, got.height, got.see,
                     got.rdist, got.side, got.x, got.y, got.last);
          end
        end
      end
    end
  end

  task automatic send_item(logic k, logic [5:0] cx, logic [5:0] cy, logic [7:0] code,
                           logic [23:0] col, logic [7:0] ht, logic see,
                           logic [21:0] ox, logic [21:0] oy,
                           logic signed [15:0] dx, logic signed [15:0] dy);
    while ($urandom_range(99) < sender_idle_pct) @(negedge clk_i);
    kind_i = k;
    cell_x_i = cx;
    cell_y_i = cy;
    tile_code_i = code;
    tile_color_i = col;
    tile_height_i = ht;
    tile_see_through_i = see;
    origin_x_i = ox;
    origin_y_i = oy;
    dir_x_i = dx;
    dir_y_i = dy;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    if (k == KIND_WRITE) begin
      map_code[{cy, cx}] = code;
      map_color[{cy, cx}] = col;
      map_height[{cy, cx}] = ht;
      map_see[{cy, cx}] = see;
      n_writes++;
    end else begin
      trace_ray(ox, oy, dx, dy);
      n_casts++;
    end
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  task automatic write_tile(int x, int y, logic [7:0] code, logic see);
    send_item(KIND_WRITE, 6'(x), 6'(y), code, 24'($urandom), 8'($urandom), see,
              22'($urandom), 22'($urandom), 16'($urandom), 16'($urandom));
  endtask

  task automatic cast_ray(logic [21:0] ox, logic [21:0] oy, logic signed [15:0] dx,
                          logic signed [15:0] dy);
    send_item(KIND_CAST, 6'($urandom), 6'($urandom), 8'($urandom), 24'($urandom),
              8'($urandom), 1'($urandom), ox, oy, dx, dy);
  endtask

  task automatic drain();
    while (hits_pending.size() != 0) @(negedge clk_i);
    repeat (50) @(negedge clk_i);
  endtask

  task automatic set_max_distance(logic [21:0] v);
    drain();
    cfg_data_i = v;
    cfg_valid_i = 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    max_dist_q = v;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic test_directed();
    sender_idle_pct = 0;
    recv_stall_pct = 0;
    // row of transparent tiles exceeding the transparent-result limit, solid at the end
    for (int x = 1; x <= MAX_TILES; x++) write_tile(x, 2, (x == 1) ? 8'hFF : 8'(x), 1'b1);
    send_item(KIND_WRITE, 6'd18, 6'd2, 8'd1, 24'hFFFFFF, 8'hFF, 1'b0, '0, '0, '0, '0);
    cast_ray({6'd0, 16'h8000}, {6'd2, 16'h8000}, 16'sd16384, 16'sd0);
    cast_ray({6'd20, 16'h0}, {6'd5, 16'h0}, 16'sd0, 16'sd0);
    cast_ray(22'h3FFFFF, 22'h3FFFFF, -16'sd32768, -16'sd32768);
    cast_ray('0, '0, 16'sd32767, 16'sd32767);
    drain();
    // empty transparent cell in a column walk
    write_tile(5, 2, 8'd0, 1'b1);
    cast_ray({6'd5, 16'h1234}, {6'd0, 16'h0}, 16'sd0, 16'sd9000);
    set_max_distance('0);
    cast_ray({6'd3, 16'h0}, {6'd2, 16'h8000}, 16'sd5000, -16'sd7);
    set_max_distance(22'h3FFFFF);
    cast_ray({6'd63, 16'hFFFF}, {6'd2, 16'h8000}, -16'sd32768, 16'sd1);
    drain();
  endtask

  task automatic test_random(int unsigned items, int unsigned idle, int unsigned stall,
                             logic [21:0] maxd);
    logic signed [15:0] dx, dy;
    logic [21:0] ox, oy;
    int unsigned m;
    set_max_distance(maxd);
    sender_idle_pct = idle;
    recv_stall_pct = stall;
    for (int unsigned i = 0; i < items; i++) begin
      if ($urandom_range(99) < 45) begin
        if ($urandom_range(99) < 80)
          send_item(KIND_WRITE, 6'($urandom_range(16, 31)), 6'($urandom_range(16, 31)),
                    ($urandom_range(3) == 0) ? 8'd0 : 8'($urandom), 24'($urandom),
                    8'($urandom), 1'($urandom_range(1)), 22'($urandom), 22'($urandom),
                    16'($urandom), 16'($urandom));
        else
          send_item(KIND_WRITE, 6'($urandom), 6'($urandom), 8'($urandom), 24'($urandom),
                    8'($urandom), 1'($urandom_range(1)), 22'($urandom), 22'($urandom),
                    16'($urandom), 16'($urandom));
      end else begin
        ox = 22'($urandom);
        oy = 22'($urandom);
        if ($urandom_range(99) < 80) begin
          ox[21:16] = 6'($urandom_range(16, 31));
          oy[21:16] = 6'($urandom_range(16, 31));
        end
        dx = 16'($urandom);
        dy = 16'($urandom);
        m = $urandom_range(19);
        if (m == 0) dx = '0;
        else if (m == 1) dy = '0;
        else if (m == 2) begin
          dx = '0;
          dy = '0;
        end
        cast_ray(ox, oy, dx, dy);
      end
      if (i == items / 2 && idle != 0) drain();
    end
  endtask

  initial begin
    for (int i = 0; i < MAP_SIDE * MAP_SIDE; i++) begin
      map_code[i] = '0;
      map_color[i] = '0;
      map_height[i] = '0;
      map_see[i] = 1'b0;
    end
    max_dist_q = gdda_pkg::MAXD_RESET;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_random(90, 0, 0, gdda_pkg::MAXD_RESET);
    test_random(90, 88, 0, 22'h3FFFFF);
    test_random(90, 0, 88, 22'd400000);
    test_random(90, 30, 30, 22'd1);
    drain();
    repeat (200) @(negedge clk_i);
    $display("covered %0d casts and %0d map writes, %0d results (%0d transparent)",
             n_casts, n_writes, n_results, n_transp);
    $display("%0d mismatches", mismatches);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
